>>> rtl/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [6:0] PAD_CHAR    = 7'h3D;
   localparam logic [6:0] UPPER_BASE  = 7'd65;
   localparam logic [6:0] LOWER_BASE  = 7'd71;
   localparam logic [6:0] DIGIT_SHIFT = 7'd4;
   localparam logic [6:0] PLUS_CHAR   = 7'h2B;
   localparam logic [6:0] SLASH_CHAR  = 7'h2F;

   localparam logic [1:0] PADS_NONE = 2'd0;
   localparam logic [1:0] PADS_ONE  = 2'd1;
   localparam logic [1:0] PADS_TWO  = 2'd2;

   localparam logic [1:0] SLOT_LAST = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] symbol;
      logic       group_end;
      logic       message_end;
   } rsp_type;

   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  pads;
      logic        last;
   } group_type;

   typedef struct packed {
      logic      push;
      group_type group;
   } push_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] idx);
      logic [6:0] idx7;
      logic [6:0] result;
      idx7 = {1'b0, idx};
      if (idx < 6'd26) begin
         result = idx7 + UPPER_BASE;
      end else if (idx < 6'd52) begin
         result = idx7 + LOWER_BASE;
      end else if (idx < 6'd62) begin
         result = idx7 - DIGIT_SHIFT;
      end else if (idx == 6'd62) begin
         result = PLUS_CHAR;
      end else begin
         result = SLASH_CHAR;
      end
      return result;
   endfunction

endpackage

>>> rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder.
// One message byte enters per word; a third byte, or a byte flagged final, closes a
// group that is encoded into four ASCII characters of the standard alphabet, with
// '=' padding on a short final group. Bytes are taken one per cycle as long as the
// group queue (QUEUE_DEPTH groups) has room; characters leave one per cycle from a
// registered output while the output is not stalled, so the sustained rate is set
// by the single character output, four characters per three bytes; a short final
// group still yields four characters. With the output idle, a group's first character
// passes the queue entry, the group register and the output register in turn.
module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64e_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   push_type  wr;
   logic      queue_full;
   logic      queue_pop;
   logic      queue_not_empty;
   group_type queue_group;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .wr         (wr)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .rd_group  (queue_group)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_group     (queue_group),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

>>> rtl/b64e_queue.sv
// Small first-in first-out queue of encoded-group records between front and back.
module b64e_queue #(
   parameter int unsigned DEPTH = b64e_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  b64e_pkg::push_type  wr,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output b64e_pkg::group_type rd_group
);
   import b64e_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   group_type         entry_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_group  = entry_ff[rd_ptr_ff];
   assign do_push   = wr.push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr.group;
      end
   end

endmodule

>>> rtl/b64e_front.sv
// Input side: collects bytes into 24-bit groups and hands finished groups to the queue.
module b64e_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b64e_pkg::req_type  req_data,
   input  logic               queue_full,
   output b64e_pkg::push_type wr
);
   import b64e_pkg::*;

   logic [7:0] pending_ff [2];
   logic [1:0] count_ff, count_in;
   logic       accept, store;
   logic [7:0] byte_a, byte_b, byte_c;
   logic [1:0] pads;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign store     = (count_ff < 2'd2) && !req_data.final_byte;

   always_comb begin
      byte_a = req_data.data_byte;
      byte_b = '0;
      byte_c = '0;
      pads   = PADS_TWO;
      if (count_ff == 2'd1) begin
         byte_a = pending_ff[0];
         byte_b = req_data.data_byte;
         pads   = PADS_ONE;
      end else if (count_ff >= 2'd2) begin
         byte_a = pending_ff[0];
         byte_b = pending_ff[1];
         byte_c = req_data.data_byte;
         pads   = PADS_NONE;
      end
   end

   always_comb begin
      wr.push       = accept && !store;
      wr.group.bits = {byte_a, byte_b, byte_c};
      wr.group.pads = pads;
      wr.group.last = req_data.final_byte;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = store ? count_ff + 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         pending_ff[count_ff[0]] <= req_data.data_byte;
      end
   end

endmodule

>>> rtl/b64e_back.sv
// Output side: turns each queued group into four characters, one per cycle while the output is not stalled.
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_not_empty,
   input  b64e_pkg::group_type queue_group,
   output logic                queue_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b64e_pkg::rsp_type   rsp_data
);
   import b64e_pkg::*;

   group_type  group_ff;
   logic       active_ff, active_in;
   logic [1:0] slot_ff, slot_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       out_load;
   logic       load_group;
   logic [5:0] sextet;
   logic       is_pad;
   rsp_type    next_sym;

   assign out_load   = active_ff && (!out_valid_ff || !rsp_stall);
   assign queue_pop  = !active_ff || (out_load && slot_ff == SLOT_LAST);
   assign load_group = queue_pop && queue_not_empty;

   always_comb begin
      case (slot_ff)
         2'd0:    sextet = group_ff.bits[23:18];
         2'd1:    sextet = group_ff.bits[17:12];
         2'd2:    sextet = group_ff.bits[11:6];
         default: sextet = group_ff.bits[5:0];
      endcase
      is_pad = ((group_ff.pads == PADS_TWO) && (slot_ff >= 2'd2))
            || ((group_ff.pads != PADS_NONE) && (slot_ff == SLOT_LAST));
      next_sym.symbol      = is_pad ? PAD_CHAR : sextet_char(sextet);
      next_sym.group_end   = (slot_ff == SLOT_LAST);
      next_sym.message_end = (slot_ff == SLOT_LAST) && group_ff.last;
   end

   always_comb begin
      active_in    = active_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_valid_in = 1'b1;
         slot_in      = slot_ff + 2'd1;
         if (slot_ff == SLOT_LAST) begin
            active_in = 1'b0;
         end
      end
      if (load_group) begin
         active_in = 1'b1;
         slot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_group) begin
         group_ff <= queue_group;
      end
      if (out_load) begin
         out_ff <= next_sym;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/b64e_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
module b64e_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input b64e_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("Stalled request word changed or was withdrawn.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result word changed or was dropped.");

   a_msg_end_on_group_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_end |-> rsp_data.group_end)
      else $error("Message end flagged away from a group end.");

   a_pad_only_at_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.group_end && (rsp_data.symbol == PAD_CHAR)
         |-> rsp_data.message_end)
      else $error("Padding in a group that does not end the message.");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word valid right after reset.");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);

>>> tb/tb_base64_stream_encoder.sv
// Self-checking testbench for the streaming base64 encoder, with directed and random messages.
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
   import b64e_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int REPORT_LIMIT = 200;
   localparam logic [8*64-1:0] ALPHABET_TEXT =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type   expected_symbols[$];
   logic [7:0] held_bytes[2];
   int        held_count = 0;
   int        error_count = 0;
   int        bytes_accepted = 0;
   int        messages_closed = 0;
   int        symbols_checked = 0;
   int        cycle_count = 0;

   stall_type stall_mode = STALL_NONE;
   int        stall_phase = 0;
   int        hold_request = 0;
   int        hold_left = 0;
   bit        sender_gaps = 1'b0;
   int        burst_left = 0;

   base64_stream_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void encode_byte(input req_type word);
      logic [23:0] group_bits;
      logic [5:0]  sextet;
      int          pad_count;
      int          k;
      rsp_type     sym;
      if (held_count < 2 && !word.final_byte) begin
         held_bytes[held_count] = word.data_byte;
         held_count++;
         return;
      end
      case (held_count)
         0: begin
            group_bits = {word.data_byte, 16'h0000};
         end
         1: begin
            group_bits = {held_bytes[0], word.data_byte, 8'h00};
         end
         default: begin
            group_bits = {held_bytes[0], held_bytes[1], word.data_byte};
         end
      endcase
      pad_count = 2 - held_count;
      for (k = 0; k < 4; k++) begin
         sextet = group_bits[18 - 6 * k +: 6];
         if (k >= 4 - pad_count) begin
            sym.symbol = PAD_CHAR;
         end else begin
            sym.symbol = ALPHABET_TEXT[8 * (63 - sextet) +: 7];
         end
         sym.group_end = (k == 3);
         sym.message_end = word.final_byte && (k == 3);
         expected_symbols.push_back(sym);
      end
      held_count = 0;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data);
            bytes_accepted++;
            if (req_data.final_byte) begin
               messages_closed++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected word, expected none actual %h", $time, rsp_data);
               end
            end else begin
               want = expected_symbols.pop_front();
               symbols_checked++;
               if (rsp_data.symbol !== want.symbol) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: symbol mismatch, expected %h actual %h",
                              $time, want.symbol, rsp_data.symbol);
                  end
               end
               if (rsp_data.group_end !== want.group_end) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: group_end mismatch, expected %b actual %b",
                              $time, want.group_end, rsp_data.group_end);
                  end
               end
               if (rsp_data.message_end !== want.message_end) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: message_end mismatch, expected %b actual %b",
                              $time, want.message_end, rsp_data.message_end);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         case (stall_mode)
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_PATTERN: begin
               stall_phase = (stall_phase + 1) % 5;
               rsp_stall <= (stall_phase < 2);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words still expected", $time, expected_symbols.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: value, final_byte: last};
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return 8'h00;
      end else if (pick == 1) begin
         return 8'hFF;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic test_single_byte_messages();
      stall_mode = STALL_NONE;
      sender_gaps = 1'b0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_two_byte_messages();
      stall_mode = STALL_RANDOM;
      sender_gaps = 1'b1;
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   task automatic test_full_groups();
      stall_mode = STALL_PATTERN;
      sender_gaps = 1'b0;
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h51, 1'b1);
   endtask

   task automatic test_random_messages(input int item_target, input stall_type kind,
                                       input bit with_gaps);
      int sent;
      int msg_len;
      int i;
      stall_mode = kind;
      sender_gaps = with_gaps;
      sent = 0;
      while (sent < item_target) begin
         msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
         for (i = 0; i < msg_len; i++) begin
            send_byte(random_byte(), i == msg_len - 1);
            sent++;
         end
      end
   endtask

   task automatic test_output_backpressure();
      int i;
      stall_mode = STALL_NONE;
      sender_gaps = 1'b0;
      hold_request = 80;
      for (i = 0; i < 30; i++) begin
         send_byte(random_byte(), i == 29);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_byte_messages();
      test_two_byte_messages();
      test_full_groups();
      test_random_messages(60, STALL_RANDOM, 1'b1);
      test_random_messages(50, STALL_NONE, 1'b0);
      test_output_backpressure();
      test_random_messages(50, STALL_PATTERN, 1'b1);
      test_random_messages(60, STALL_HEAVY, 1'b1);
      req_valid <= 1'b0;
      stall_mode = STALL_NONE;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Encoded %0d bytes in %0d messages and checked %0d output characters,",
               bytes_accepted, messages_closed, symbols_checked);
      $display("covering padded and full groups under gaps, output stalls and a long hold-off.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
